FILE: hw/rtl/ktd_pkg.sv
// Shared types and constants of the keyed trailing-edge debouncer.
package ktd_pkg;

    localparam int VID_W           = 16;
    localparam int PID_W           = 16;
    localparam int TAG_W           = 64;
    localparam int CNT_W           = 16;
    localparam int DEFAULT_ENTRIES = 8;
    localparam int MAX_RESULTS     = 8;

    localparam logic [CNT_W-1:0] TICKS_RESET = 16'd300;

    localparam logic KIND_EVENT = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // One stored table entry.
    typedef struct packed {
        logic [VID_W-1:0] vendor;
        logic [PID_W-1:0] product;
        logic [TAG_W-1:0] serial;
        logic             action;
        logic [CNT_W-1:0] countdown;
    } ktd_entry_t;

    // One result as it leaves the block.
    typedef struct packed {
        logic [VID_W-1:0] vendor;
        logic [PID_W-1:0] product;
        logic [TAG_W-1:0] serial;
        logic             removed;
        logic             passed;
        logic             last;
    } ktd_result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic cap;
        logic rd;
        logic chk;
        logic fin;
    } ktd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic match;
        logic idx_last;
        logic chk_stall;
        logic fin_stall;
    } ktd_sts_t;

endpackage

FILE: hw/rtl/keyed_trailing_edge_debouncer.sv
// Top level of the keyed trailing-edge debouncer for attach and detach events.
//
// The input channel (s_*) carries one request per item: either a hotplug event
// (s_kind = 0) keyed by vendor id, product id and serial tag, or a time tick
// (s_kind = 1). The result channel (m_*) carries coalesced events; m_last marks
// the final result caused by one request. The configuration channel (cfg_*)
// sets the quiet window in ticks and is always ready; it takes effect at once.
//
// Every request walks the entry table one entry at a time through the single
// read port of the table RAM: it is accepted in the idle state, then takes a
// read state and a check state per entry, and ends in a finish state. An
// event that hits a pending key finishes as soon as the hit is seen. A tick
// emits up to eight results, which leave through a one-deep output register,
// so a stalled receiver holds the walk until the output register drains.
// A new request is taken while the last result of the previous one still
// waits in the output register.
//
// Reset (aresetn low, synchronous) frees every entry, empties the output
// register and sets the window to 300 ticks. No clearing pass is needed.
module keyed_trailing_edge_debouncer import ktd_pkg::*; #(
    parameter int ENTRIES = DEFAULT_ENTRIES
) (
    input  logic             aclk,
    input  logic             aresetn,

    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_kind,
    input  logic [VID_W-1:0] s_vendor_id,
    input  logic [PID_W-1:0] s_product_id,
    input  logic [TAG_W-1:0] s_serial_tag,
    input  logic             s_removed,

    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CNT_W-1:0] cfg_debounce_ticks,

    output logic             m_valid,
    input  logic             m_ready,
    output logic [VID_W-1:0] m_out_vendor_id,
    output logic [PID_W-1:0] m_out_product_id,
    output logic [TAG_W-1:0] m_out_serial_tag,
    output logic             m_out_removed,
    output logic             m_passed_through,
    output logic             m_last
);

    ktd_cmd_t    cmd;
    ktd_sts_t    sts;
    ktd_result_t m_data;

    // The window register can be written in any cycle.
    assign cfg_ready = 1'b1;

    // The controller sequences the table walk; it sees only s_valid and the status flags.
    ktd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // The datapath holds the table, the scan state and the output register.
    ktd_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .sts                (sts),
        .s_kind             (s_kind),
        .s_vendor_id        (s_vendor_id),
        .s_product_id       (s_product_id),
        .s_serial_tag       (s_serial_tag),
        .s_removed          (s_removed),
        .cfg_valid          (cfg_valid),
        .cfg_debounce_ticks (cfg_debounce_ticks),
        .m_ready            (m_ready),
        .m_valid            (m_valid),
        .m_data             (m_data)
    );

    // Unpack the result register onto the individual result ports.
    assign m_out_vendor_id  = m_data.vendor;
    assign m_out_product_id = m_data.product;
    assign m_out_serial_tag = m_data.serial;
    assign m_out_removed    = m_data.removed;
    assign m_passed_through = m_data.passed;
    assign m_last           = m_data.last;

endmodule

FILE: hw/rtl/ktd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ktd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                     aclk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/ktd_ctrl.sv
// Sequencer that walks the entry table once per accepted request.
module ktd_ctrl import ktd_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ktd_sts_t sts,
    output ktd_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RD   = 4'b0010,
        ST_CHK  = 4'b0100,
        ST_FIN  = 4'b1000
    } ktd_state_t;

    ktd_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.cap    = 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                cmd.rd     = 1'b1;
                state_next = ST_CHK;
            end
            ST_CHK: begin
                if (!sts.chk_stall) begin
                    cmd.chk = 1'b1;
                    if (sts.match) begin
                        state_next = ST_IDLE;
                    end else if (sts.idx_last) begin
                        state_next = ST_FIN;
                    end else begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_FIN: begin
                if (!sts.fin_stall) begin
                    cmd.fin    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/ktd_datapath.sv
// Entry table, scan registers, pending result and output register.
module ktd_datapath import ktd_pkg::*; #(
    parameter int ENTRIES = DEFAULT_ENTRIES
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  ktd_cmd_t         cmd,
    output ktd_sts_t         sts,
    input  logic             s_kind,
    input  logic [VID_W-1:0] s_vendor_id,
    input  logic [PID_W-1:0] s_product_id,
    input  logic [TAG_W-1:0] s_serial_tag,
    input  logic             s_removed,
    input  logic             cfg_valid,
    input  logic [CNT_W-1:0] cfg_debounce_ticks,
    input  logic             m_ready,
    output logic             m_valid,
    output ktd_result_t      m_data
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int NRES_W = $clog2(MAX_RESULTS + 1);

    logic [CNT_W-1:0]   ticks_reg;
    logic               kind_reg;
    logic [VID_W-1:0]   vid_reg;
    logic [PID_W-1:0]   pid_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic               act_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               free_found_reg;
    logic [IDX_W-1:0]   free_idx_reg;
    logic [NRES_W-1:0]  n_reg;
    logic               pend_valid_reg;
    ktd_result_t        pend_reg;
    logic               m_valid_reg;
    ktd_result_t        m_data_reg;
    logic [ENTRIES-1:0] live_reg;

    ktd_entry_t       rd_entry;
    ktd_entry_t       new_entry;
    ktd_entry_t       dec_entry;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    ktd_entry_t       wr_data;
    logic [CNT_W-1:0] win;
    logic [CNT_W-1:0] cd_dec;
    logic             live_i;
    logic             key_eq;
    logic             expire;
    logic             out_free;
    logic             out_load_mid;
    logic             out_load_fin;

    ktd_ram #(
        .WIDTH ($bits(ktd_entry_t)),
        .DEPTH (ENTRIES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd),
        .rd_addr (idx_reg),
        .rd_data (rd_entry)
    );

    // A zero window behaves as a one-tick window.
    assign win = (ticks_reg == '0) ? CNT_W'(1) : ticks_reg;

    assign live_i = live_reg[idx_reg];
    assign key_eq = (rd_entry.vendor == vid_reg) && (rd_entry.product == pid_reg) &&
                    (rd_entry.serial == tag_reg);
    assign cd_dec = (rd_entry.countdown != '0) ? (rd_entry.countdown - CNT_W'(1)) : '0;
    assign expire = live_i && (cd_dec == '0) && (n_reg < NRES_W'(MAX_RESULTS));
    assign out_free = !m_valid_reg || m_ready;

    assign sts.match     = (kind_reg == KIND_EVENT) && live_i && key_eq;
    assign sts.idx_last  = (idx_reg == IDX_W'(ENTRIES - 1));
    assign sts.chk_stall = (kind_reg == KIND_TICK) && expire && pend_valid_reg && !out_free;
    assign sts.fin_stall = ((kind_reg == KIND_TICK) ? pend_valid_reg : !free_found_reg) &&
                           !out_free;

    always_comb begin
        new_entry.vendor    = vid_reg;
        new_entry.product   = pid_reg;
        new_entry.serial    = tag_reg;
        new_entry.action    = act_reg;
        new_entry.countdown = win;
        dec_entry           = rd_entry;
        dec_entry.countdown = cd_dec;
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = new_entry;
        if (cmd.chk) begin
            if (kind_reg == KIND_EVENT) begin
                wr_en = sts.match;
            end else if (live_i && !expire) begin
                wr_en   = 1'b1;
                wr_data = dec_entry;
            end
        end
        if (cmd.fin && (kind_reg == KIND_EVENT) && free_found_reg) begin
            wr_en   = 1'b1;
            wr_addr = free_idx_reg;
        end
    end

    assign out_load_mid = cmd.chk && (kind_reg == KIND_TICK) && expire && pend_valid_reg;
    assign out_load_fin = cmd.fin &&
                          ((kind_reg == KIND_TICK) ? pend_valid_reg : !free_found_reg);

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_reg      <= TICKS_RESET;
            idx_reg        <= '0;
            free_found_reg <= 1'b0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            live_reg       <= '0;
            kind_reg       <= KIND_EVENT;
        end else begin
            if (cfg_valid) begin
                ticks_reg <= cfg_debounce_ticks;
            end
            if (out_load_mid || out_load_fin) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.cap) begin
                kind_reg       <= s_kind;
                idx_reg        <= '0;
                free_found_reg <= 1'b0;
                n_reg          <= '0;
                pend_valid_reg <= 1'b0;
            end
            if (cmd.chk) begin
                if (!sts.idx_last) begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
                if ((kind_reg == KIND_EVENT) && !live_i && !free_found_reg) begin
                    free_found_reg <= 1'b1;
                end
                if ((kind_reg == KIND_TICK) && expire) begin
                    live_reg[idx_reg] <= 1'b0;
                    n_reg             <= n_reg + NRES_W'(1);
                    pend_valid_reg    <= 1'b1;
                end
            end
            if (cmd.fin) begin
                if (kind_reg == KIND_TICK) begin
                    pend_valid_reg <= 1'b0;
                end else if (free_found_reg) begin
                    live_reg[free_idx_reg] <= 1'b1;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.cap) begin
            vid_reg <= s_vendor_id;
            pid_reg <= s_product_id;
            tag_reg <= s_serial_tag;
            act_reg <= s_removed;
        end
        if (cmd.chk && (kind_reg == KIND_EVENT) && !live_i && !free_found_reg) begin
            free_idx_reg <= idx_reg;
        end
        if (cmd.chk && (kind_reg == KIND_TICK) && expire) begin
            pend_reg.vendor  <= rd_entry.vendor;
            pend_reg.product <= rd_entry.product;
            pend_reg.serial  <= rd_entry.serial;
            pend_reg.removed <= rd_entry.action;
            pend_reg.passed  <= 1'b0;
            pend_reg.last    <= 1'b0;
        end
        if (out_load_mid) begin
            m_data_reg <= pend_reg;
        end else if (out_load_fin) begin
            if (kind_reg == KIND_TICK) begin
                m_data_reg.vendor  <= pend_reg.vendor;
                m_data_reg.product <= pend_reg.product;
                m_data_reg.serial  <= pend_reg.serial;
                m_data_reg.removed <= pend_reg.removed;
                m_data_reg.passed  <= pend_reg.passed;
                m_data_reg.last    <= 1'b1;
            end else begin
                m_data_reg.vendor  <= vid_reg;
                m_data_reg.product <= pid_reg;
                m_data_reg.serial  <= tag_reg;
                m_data_reg.removed <= act_reg;
                m_data_reg.passed  <= 1'b1;
                m_data_reg.last    <= 1'b1;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_live_reset: assert property (@(posedge aclk) !aresetn |=> (live_reg == '0))
        else $error("entries live after reset");

    a_n_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= NRES_W'(MAX_RESULTS))
        else $error("too many expiries in one tick");

    a_fin_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fin && (kind_reg == KIND_EVENT) && free_found_reg |-> !live_reg[free_idx_reg])
        else $error("new event allocated into a live entry");

    a_pend_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> (kind_reg == KIND_TICK))
        else $error("pending expiry outside a tick");

    a_pass_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.passed |-> m_data_reg.last)
        else $error("pass-through result without last marker");

endmodule

FILE: dv/tb_keyed_trailing_edge_debouncer.sv
// Self-checking testbench for the keyed trailing-edge debouncer.
`timescale 1ns / 1ps

module tb_keyed_trailing_edge_debouncer import ktd_pkg::*; ();

    localparam int ENTRIES      = DEFAULT_ENTRIES;
    localparam int POOL_KEYS    = 12;
    localparam int RAND_PHASES  = 5;
    localparam int PHASE_ITEMS  = 80;
    // Waiting this long after the owed results drain outlasts the table walk of
    // a request, so an absorbed event has been fully written back.
    localparam int SETTLE_CYCLES = 4 * ENTRIES + 8;
    // One long receiver hold-off so the output register fills and the block
    // has to push back on its input channel.
    localparam int HOLD_CYCLES   = 500;
    localparam int HOLD_AFTER    = 25;
    // Far beyond the slowest legal run.
    localparam longint TIMEOUT_NS = 64'd8_000_000;

    // Scoreboard: shadow copy of the pending-event table and the queue of
    // coalesced events that the block still owes us.
    class debounce_scoreboard;
        bit [CNT_W-1:0] window;
        bit             live      [ENTRIES];
        bit [VID_W-1:0] vendor    [ENTRIES];
        bit [PID_W-1:0] product   [ENTRIES];
        bit [TAG_W-1:0] serial    [ENTRIES];
        bit             action    [ENTRIES];
        bit [CNT_W-1:0] countdown [ENTRIES];
        ktd_result_t    owed_q[$];
        int             n_errors;

        function new();
            window   = TICKS_RESET;
            n_errors = 0;
            foreach (live[i]) live[i] = 1'b0;
        endfunction

        function int outstanding();
            return owed_q.size();
        endfunction

        // Update the shadow table for one accepted request and queue the
        // events it releases.
        function void note_request(bit kind, bit [VID_W-1:0] vid, bit [PID_W-1:0] pid,
                                   bit [TAG_W-1:0] tag, bit rem);
            bit [CNT_W-1:0] span;
            int             free_slot;
            int             first;
            ktd_result_t    ev;

            span      = (window == '0) ? CNT_W'(1) : window;
            free_slot = -1;
            first     = owed_q.size();
            if (kind == KIND_EVENT) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (live[i]) begin
                        if (vendor[i] == vid && product[i] == pid && serial[i] == tag) begin
                            // Same device again: keep the newest action and
                            // restart its quiet window.
                            action[i]    = rem;
                            countdown[i] = span;
                            return;
                        end
                    end else if (free_slot < 0) begin
                        free_slot = i;
                    end
                end
                if (free_slot >= 0) begin
                    live[free_slot]      = 1'b1;
                    vendor[free_slot]    = vid;
                    product[free_slot]   = pid;
                    serial[free_slot]    = tag;
                    action[free_slot]    = rem;
                    countdown[free_slot] = span;
                    return;
                end
                // Table full: the event bypasses debouncing.
                ev = '{vendor: vid, product: pid, serial: tag, removed: rem,
                       passed: 1'b1, last: 1'b1};
                owed_q.push_back(ev);
                return;
            end
            for (int i = 0; i < ENTRIES; i++) begin
                if (live[i] && countdown[i] != '0) countdown[i] = countdown[i] - CNT_W'(1);
            end
            for (int i = 0; i < ENTRIES; i++) begin
                if (live[i] && countdown[i] == '0 && owed_q.size() - first < MAX_RESULTS) begin
                    ev = '{vendor: vendor[i], product: product[i], serial: serial[i],
                           removed: action[i], passed: 1'b0, last: 1'b0};
                    owed_q.push_back(ev);
                    live[i] = 1'b0;
                end
            end
            if (owed_q.size() > first) owed_q[owed_q.size() - 1].last = 1'b1;
        endfunction

        // Compare one accepted result with the oldest owed event.
        function void check_result(ktd_result_t got);
            ktd_result_t want;

            if (owed_q.size() == 0) begin
                $error("unexpected result: vendor %h product %h serial %h",
                       got.vendor, got.product, got.serial);
                n_errors++;
                return;
            end
            want = owed_q.pop_front();
            if (got.vendor !== want.vendor) begin
                $error("out_vendor_id: expected %h, actual %h", want.vendor, got.vendor);
                n_errors++;
            end
            if (got.product !== want.product) begin
                $error("out_product_id: expected %h, actual %h", want.product, got.product);
                n_errors++;
            end
            if (got.serial !== want.serial) begin
                $error("out_serial_tag: expected %h, actual %h", want.serial, got.serial);
                n_errors++;
            end
            if (got.removed !== want.removed) begin
                $error("out_removed: expected %b, actual %b", want.removed, got.removed);
                n_errors++;
            end
            if (got.passed !== want.passed) begin
                $error("passed_through: expected %b, actual %b", want.passed, got.passed);
                n_errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %b, actual %b", want.last, got.last);
                n_errors++;
            end
        endfunction
    endclass

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic             s_kind;
    logic [VID_W-1:0] s_vendor_id;
    logic [PID_W-1:0] s_product_id;
    logic [TAG_W-1:0] s_serial_tag;
    logic             s_removed;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_debounce_ticks;
    logic             m_valid;
    logic             m_ready;
    logic [VID_W-1:0] m_out_vendor_id;
    logic [PID_W-1:0] m_out_product_id;
    logic [TAG_W-1:0] m_out_serial_tag;
    logic             m_out_removed;
    logic             m_passed_through;
    logic             m_last;

    debounce_scoreboard sb = new();

    // When set, neither side inserts idle cycles.
    bit steady;
    int n_requests;
    int n_ticks;
    int n_results;
    int n_passed;

    keyed_trailing_edge_debouncer u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_kind             (s_kind),
        .s_vendor_id        (s_vendor_id),
        .s_product_id       (s_product_id),
        .s_serial_tag       (s_serial_tag),
        .s_removed          (s_removed),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_debounce_ticks (cfg_debounce_ticks),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_out_vendor_id    (m_out_vendor_id),
        .m_out_product_id   (m_out_product_id),
        .m_out_serial_tag   (m_out_serial_tag),
        .m_out_removed      (m_out_removed),
        .m_passed_through   (m_passed_through),
        .m_last             (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("keyed_trailing_edge_debouncer regression: fail");
        $finish;
    end

    // Idle length for either side: mostly none, sometimes short, and now and
    // then a long gap.
    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Offer one request and hold it until the block takes it. Valid is only
    // lowered when a gap precedes the next request, so back-to-back requests
    // keep valid high without a glitch.
    task automatic send_req(input bit kind, input bit [VID_W-1:0] vid,
                            input bit [PID_W-1:0] pid, input bit [TAG_W-1:0] tag,
                            input bit rem);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_kind       <= kind;
        s_vendor_id  <= vid;
        s_product_id <= pid;
        s_serial_tag <= tag;
        s_removed    <= rem;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(kind, vid, pid, tag, rem);
        n_requests++;
        if (kind == KIND_TICK) n_ticks++;
    endtask

    // A tick carries junk in the event fields; the block must ignore it.
    task automatic send_tick();
        send_req(KIND_TICK, VID_W'($urandom), PID_W'($urandom), {$urandom, $urandom},
                 1'($urandom_range(1)));
    endtask

    // Stop offering requests, let every owed result drain, then give the
    // block time to finish writing back any absorbed event.
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_window(input bit [CNT_W-1:0] ticks);
        cfg_valid          <= 1'b1;
        cfg_debounce_ticks <= ticks;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.window = ticks;
    endtask

    // Result side: random back-pressure, one long hold-off once traffic is
    // flowing, and a check of every accepted result.
    initial begin
        int          stall_left;
        bit          held;
        ktd_result_t got;

        m_ready    <= 1'b0;
        stall_left = 0;
        held       = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                got.vendor  = m_out_vendor_id;
                got.product = m_out_product_id;
                got.serial  = m_out_serial_tag;
                got.removed = m_out_removed;
                got.passed  = m_passed_through;
                got.last    = m_last;
                sb.check_result(got);
                n_results++;
                if (got.passed) n_passed++;
            end
            if (!held && n_results >= HOLD_AFTER) begin
                // The sender keeps offering requests during this stretch.
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                stall_left = pick_gap();
                m_ready <= (stall_left == 0);
                if (stall_left > 0) stall_left--;
            end
        end
    end

    // Stimulus: a directed pass over the corner cases, then random phases
    // under different quiet windows.
    initial begin
        bit [VID_W-1:0] key_vid [ENTRIES];
        bit [PID_W-1:0] key_pid [ENTRIES];
        bit [TAG_W-1:0] key_tag [ENTRIES];
        bit [VID_W-1:0] pool_vid [POOL_KEYS];
        bit [PID_W-1:0] pool_pid [POOL_KEYS];
        bit [TAG_W-1:0] pool_tag [POOL_KEYS];
        bit [CNT_W-1:0] phase_window [RAND_PHASES];
        bit [VID_W-1:0] base_vid;
        bit [PID_W-1:0] base_pid;
        bit [TAG_W-1:0] base_tag;
        bit [VID_W-1:0] one_vid;
        bit [PID_W-1:0] one_pid;
        bit [TAG_W-1:0] one_tag;
        int             r;
        int             k;

        key_vid = '{16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF,
                    16'h0001, 16'h8000, 16'h7FFF, 16'h1234};
        key_pid = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
                    16'h0001, 16'h8000, 16'h7FFF, 16'h5678};
        key_tag = '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF,
                    64'h8000_0000_0000_0001, 64'h5555_5555_5555_5555,
                    64'hAAAA_AAAA_AAAA_AAAA, 64'h0123_4567_89AB_CDEF};
        phase_window = '{16'd1, 16'd3, 16'd2, 16'd5, 16'd1};
        steady = 1'b0;

        aresetn            <= 1'b0;
        s_valid            <= 1'b0;
        s_kind             <= KIND_EVENT;
        s_vendor_id        <= '0;
        s_product_id       <= '0;
        s_serial_tag       <= '0;
        s_removed          <= 1'b0;
        cfg_valid          <= 1'b0;
        cfg_debounce_ticks <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Under the reset window: one event that will sit in the table, then a
        // tick with nothing expired, which must produce no result.
        send_req(KIND_EVENT, key_vid[0], key_pid[0], key_tag[0], 1'b1);
        send_req(KIND_TICK, 16'hFFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);

        // Longest window: fill the table, overflow it once so the event passes
        // straight through, then hit a pending key with a new action.
        settle();
        write_window(16'hFFFF);
        for (int i = 1; i < ENTRIES; i++)
            send_req(KIND_EVENT, key_vid[i], key_pid[i], key_tag[i], i[0]);
        send_req(KIND_EVENT, 16'hAAAA, 16'h5555, 64'h0F0F_0F0F_F0F0_F0F0, 1'b1);
        send_tick();
        send_req(KIND_EVENT, key_vid[3], key_pid[3], key_tag[3], 1'b0);

        // Zero window behaves as one tick: restart all eight pending keys and
        // let a single tick release the whole table at once.
        settle();
        write_window(16'd0);
        for (int i = 0; i < ENTRIES; i++)
            send_req(KIND_EVENT, key_vid[i], key_pid[i], key_tag[i], ~i[0]);
        send_tick();

        // A repeat of the same key mid-window restarts its countdown.
        settle();
        write_window(16'd2);
        one_vid = VID_W'($urandom);
        one_pid = PID_W'($urandom);
        one_tag = {$urandom, $urandom};
        send_req(KIND_EVENT, one_vid, one_pid, one_tag, 1'b0);
        send_tick();
        send_req(KIND_EVENT, one_vid, one_pid, one_tag, 1'b1);
        send_tick();
        send_tick();

        // Random phases. Most events come from a small pool of keys so they
        // collide and coalesce; some pool keys differ from each other in one
        // field only, and a few events use fresh random keys.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            settle();
            write_window(phase_window[ph]);
            steady   = (ph == 2);
            base_vid = VID_W'($urandom);
            base_pid = PID_W'($urandom);
            base_tag = {$urandom, $urandom};
            for (int p = 0; p < POOL_KEYS; p++) begin
                pool_vid[p] = (p < 6) ? base_vid : VID_W'($urandom);
                pool_pid[p] = (p < 4) ? base_pid : PID_W'($urandom);
                pool_tag[p] = (p == 4 || p == 5) ? base_tag : {$urandom, $urandom};
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(99);
                if (r < 40) begin
                    send_tick();
                end else if (r < 90) begin
                    k = $urandom_range(POOL_KEYS - 1);
                    send_req(KIND_EVENT, pool_vid[k], pool_pid[k], pool_tag[k],
                             1'($urandom_range(1)));
                end else begin
                    send_req(KIND_EVENT, VID_W'($urandom), PID_W'($urandom),
                             {$urandom, $urandom}, 1'($urandom_range(1)));
                end
            end
        end
        steady = 1'b0;

        settle();
        $display("Covered %0d requests (%0d ticks) under windows 300, 65535, 0 and 1..5.",
                 n_requests, n_ticks);
        $display("Checked %0d coalesced events, %0d of them passed through a full table.",
                 n_results, n_passed);
        if (sb.n_errors == 0) begin
            $display("keyed_trailing_edge_debouncer regression: pass");
        end else begin
            $display("keyed_trailing_edge_debouncer regression: fail");
        end
        $finish;
    end

endmodule

FILE: keyed_trailing_edge_debouncer.f
hw/rtl/ktd_pkg.sv
hw/rtl/ktd_ram.sv
hw/rtl/ktd_ctrl.sv
hw/rtl/ktd_datapath.sv
hw/rtl/keyed_trailing_edge_debouncer.sv
dv/tb_keyed_trailing_edge_debouncer.sv
